// ===== rtl/core/triangle_normal_area_centroid_core_macros.svh =====
// Assertion macros shared by the triangle normal, area and centroid core.
`ifndef TRIANGLE_NORMAL_AREA_CENTROID_CORE_MACROS_SVH
`define TRIANGLE_NORMAL_AREA_CENTROID_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TNAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnac: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TNAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnac: next-cycle check failed");
`else
`define TNAC_ASSERT_IMP(lbl, ante, cons)
`define TNAC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/tnac_pkg.sv =====
// Widths, constants and word types of the triangle normal, area and centroid core.
package tnac_pkg;

  // Coordinate format
  localparam int CW    = 24;           // coordinate width
  localparam int CF    = 12;           // coordinate fraction bits
  localparam int EW    = CW + 1;       // edge vector component
  localparam int SUMW  = CW + 2;       // sum of three coordinates

  // Cross product
  localparam int PW    = 2 * EW;       // one partial product
  localparam int XW    = PW + 1;       // cross product component
  localparam int MW    = PW;           // cross product magnitude
  localparam int HW    = MW - EW;      // upper half of a magnitude
  localparam int SQW   = 2 * MW;       // squared magnitude and their sum

  // Area: 24 fraction bits out of 4*CF fraction bits in the squared length
  localparam int AREA_FRAC = 24;
  localparam int AREA_SHR  = 2 * (2 * CF + 1 - AREA_FRAC);
  localparam int RW        = 50;       // area root width
  localparam int RMW       = SQW + 1;  // area remainder width

  // Normal
  localparam int NF    = 14;           // normal fraction bits
  localparam int NW    = 16;           // normal output width
  localparam int YW    = 31;           // scaled magnitude width
  localparam int KW    = 5;            // scale shift width
  localparam int SSW   = 2 * YW + 2;   // sum of scaled squares
  localparam int TW    = 2 * YW + 2 * NF;
  localparam int NQW   = NF + 1;       // quotient bits searched
  localparam int NACC  = SSW + NQW + 1;
  localparam int NRW   = 96;           // normal remainder width

  // Divide by three: multiply by ceil(2^27 / 3), keep bits above 27
  localparam int DIV3_SH = 27;
  localparam logic [SUMW-1:0] DIV3_MUL = SUMW'(44739243);

  // Word handed from the front to the back
  typedef struct packed {
    logic [2:0][EW-1:0]   e1;
    logic [2:0][EW-1:0]   e2;
    logic [2:0]           cneg;
    logic [2:0][SUMW-1:0] cmag;
    logic                 degen;
  } item_t;

  // Word entering the root stages
  typedef struct packed {
    logic [SQW-1:0]       v;
    logic [SSW-1:0]       ssum;
    logic [2:0][TW-1:0]   tgt;
    logic [2:0]           neg;
    logic                 nz;
    logic [2:0][CW-1:0]   mid;
    logic                 degen;
  } root_in_t;

  // Result word
  typedef struct packed {
    logic [2:0][NW-1:0]   nrm;
    logic [RW-1:0]        area;
    logic [2:0][CW-1:0]   mid;
    logic                 degen;
  } result_t;

  // Pipeline control between the back stages and the root stages
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

// ===== rtl/core/tnac_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
module tnac_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  T     data_in,
  input  logic pop,
  output logic empty,
  output T     data_out
);
  localparam int AW = $clog2(DEPTH);

  T               mem_r [DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == (AW + 1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem_r[rd_r];

  // Advance pointers and count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + (AW + 1)'(1);
      2'b01:   cnt_nxt = cnt_r - (AW + 1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= data_in;
    end
  end

endmodule

// ===== rtl/core/tnac_front.sv =====
// Front stage: accepts a triangle, forms edges, centroid sums and the degenerate flag.
module tnac_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [2:0][tnac_pkg::CW-1:0]     va,
  input  logic [2:0][tnac_pkg::CW-1:0]     vb,
  input  logic [2:0][tnac_pkg::CW-1:0]     vc,
  output logic                             q_push,
  input  logic                             q_full,
  output tnac_pkg::item_t                  q_data
);
  import tnac_pkg::*;

  logic  vld_r, vld_nxt;
  logic  load;
  item_t item_r, item_nxt;

  assign full   = vld_r && q_full;
  assign load   = push && !full;
  assign q_push = vld_r && !q_full;
  assign q_data = item_r;

  // Classify the incoming triangle
  always_comb begin
    logic [SUMW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      item_nxt.e1[i]   = {vb[i][CW-1], vb[i]} - {va[i][CW-1], va[i]};
      item_nxt.e2[i]   = {vc[i][CW-1], vc[i]} - {va[i][CW-1], va[i]};
      s                = {{2{va[i][CW-1]}}, va[i]} + {{2{vb[i][CW-1]}}, vb[i]}
                       + {{2{vc[i][CW-1]}}, vc[i]};
      item_nxt.cneg[i] = s[SUMW-1];
      item_nxt.cmag[i] = s[SUMW-1] ? (~s + SUMW'(1)) : s;
    end
    item_nxt.degen = (va == vb) || (va == vc) || (vb == vc);
  end

  // Hold the word until the queue takes it
  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!q_full) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/tnac_root.sv =====
// Root stages: bit-per-stage square root for the area and quotient search for the normal.
module tnac_root (
  input  logic                clk,
  input  logic                rst_n,
  input  tnac_pkg::pipe_ctl_t ctl,
  input  tnac_pkg::root_in_t  din,
  output logic                out_vld,
  output tnac_pkg::result_t   dout
);
  import tnac_pkg::*;

  localparam int STEPS = RW;

  typedef struct packed {
    logic [RMW-1:0]     rem;
    logic [RW-1:0]      r;
    logic [2:0][NW-1:0] nrm;
    logic [2:0][CW-1:0] mid;
    logic               degen;
  } ar_t;

  typedef struct packed {
    logic [2:0][NRW-1:0]  rem;
    logic [2:0][NACC-1:0] acc;
    logic [2:0][NQW-1:0]  q;
    logic [SSW-1:0]       ssum;
    logic [2:0]           neg;
    logic                 nz;
  } nr_t;

  ar_t              ar_in [STEPS];
  ar_t              ar_nxt [STEPS];
  ar_t              ar_r [STEPS];
  nr_t              nr_in [NQW];
  nr_t              nr_nxt [NQW];
  nr_t              nr_r [NQW];
  logic [STEPS-1:0] v_r, v_nxt;

  // Advance valid bits with the pipeline
  assign v_nxt = {v_r[STEPS-2:0], ctl.vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl.en) begin
      v_r <= v_nxt;
    end
  end

  // Area root, one result bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_area
    localparam int B = STEPS - 1 - j;

    if (j == 0) begin : g_first
      always_comb begin
        ar_in[j].rem   = RMW'(din.v);
        ar_in[j].r     = '0;
        ar_in[j].nrm   = '0;
        ar_in[j].mid   = din.mid;
        ar_in[j].degen = din.degen;
      end
    end else if (j == NQW) begin : g_merge
      // Take the finished normal into the word
      always_comb begin
        logic [NW-1:0] qv;
        ar_in[j] = ar_r[j-1];
        for (int i = 0; i < 3; i++) begin
          qv = NW'(nr_r[NQW-1].q[i]);
          if (!nr_r[NQW-1].nz) begin
            ar_in[j].nrm[i] = '0;
          end else begin
            ar_in[j].nrm[i] = nr_r[NQW-1].neg[i] ? (~qv + NW'(1)) : qv;
          end
        end
      end
    end else begin : g_pass
      assign ar_in[j] = ar_r[j-1];
    end

    always_comb begin
      logic [RMW-1:0] trial;
      ar_nxt[j] = ar_in[j];
      trial     = (RMW'(ar_in[j].r) << (B + 1)) + (RMW'(1) << (2 * B));
      if (ar_in[j].rem >= trial) begin
        ar_nxt[j].rem = ar_in[j].rem - trial;
        ar_nxt[j].r   = ar_in[j].r | (RW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        ar_r[j] <= ar_nxt[j];
      end
    end
  end

  // Normal quotient, one bit per stage: largest q with q*q*S <= T
  for (genvar j = 0; j < NQW; j++) begin : g_norm
    localparam int B = NQW - 1 - j;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          nr_in[j].rem[i] = NRW'(din.tgt[i]);
        end
        nr_in[j].acc  = '0;
        nr_in[j].q    = '0;
        nr_in[j].ssum = din.ssum;
        nr_in[j].neg  = din.neg;
        nr_in[j].nz   = din.nz;
      end
    end else begin : g_pass
      assign nr_in[j] = nr_r[j-1];
    end

    always_comb begin
      logic [NRW-1:0] trial;
      nr_nxt[j] = nr_in[j];
      for (int i = 0; i < 3; i++) begin
        trial = (NRW'(nr_in[j].acc[i]) << (B + 1)) + (NRW'(nr_in[j].ssum) << (2 * B));
        if (nr_in[j].rem[i] >= trial) begin
          nr_nxt[j].rem[i] = nr_in[j].rem[i] - trial;
          nr_nxt[j].acc[i] = nr_in[j].acc[i] + (NACC'(nr_in[j].ssum) << B);
          nr_nxt[j].q[i]   = nr_in[j].q[i] | (NQW'(1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        nr_r[j] <= nr_nxt[j];
      end
    end
  end

  // Present the last stage; the root stays below 2^49, so the area never saturates
  assign out_vld    = v_r[STEPS-1];
  assign dout.nrm   = ar_r[STEPS-1].nrm;
  assign dout.area  = ar_r[STEPS-1].r;
  assign dout.mid   = ar_r[STEPS-1].mid;
  assign dout.degen = ar_r[STEPS-1].degen;

endmodule

// ===== rtl/core/tnac_back.sv =====
// Back pipeline: cross product, scaling, squares and centroid, then the root stages.
module tnac_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              iq_empty,
  input  tnac_pkg::item_t   iq_data,
  output logic              iq_pop,
  input  logic              oq_full,
  output logic              oq_push,
  output tnac_pkg::result_t oq_data
);
  import tnac_pkg::*;

  localparam int PRE = 7;

  function automatic logic [PW-1:0] mul_edge(logic signed [EW-1:0] a,
                                             logic signed [EW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic [2*EW-1:0] mul_half(logic [EW-1:0] a, logic [EW-1:0] b);
    logic [2*EW-1:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic [2*YW-1:0] mul_y(logic [YW-1:0] a);
    logic [2*YW-1:0] p;
    p = a * a;
    return p;
  endfunction

  function automatic logic [2*SUMW-1:0] mul_div3(logic [SUMW-1:0] a);
    logic [2*SUMW-1:0] p;
    p = a * DIV3_MUL;
    return p;
  endfunction

  pipe_ctl_t          ctl;
  logic               en;
  logic               root_vld;
  logic [PRE-1:0]     v_r, v_nxt;
  logic [PRE-2:0]     dg_r, dg_nxt;

  logic [2:0][PW-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [2:0][CW-1:0] quot_r, quot_nxt;
  logic [2:0]         cneg_r;
  logic [2:0][XW-1:0] x_r, x_nxt;
  logic [2:0][CW-1:0] mid_nxt;
  logic [2:0][CW-1:0] mid_r [2:6];
  logic [2:0][MW-1:0] mag_r, mag_nxt, mag4_r;
  logic [2:0]         neg_nxt;
  logic [2:0]         neg_r [3:6];
  logic [KW-1:0]      k_r, k_nxt;
  logic [2:0][PW-1:0] hh_r, hh_nxt, hl_r, hl_nxt, ll_r, ll_nxt;
  logic [2:0][SQW-1:0] sq_r, sq_nxt;
  logic [2:0][YW-1:0] y_r, y_nxt;
  logic [SQW-1:0]     s_r, s_nxt;
  logic [2:0][2*YW-1:0] yy_r, yy_nxt;
  root_in_t           rin_r, rin_nxt;

  // Stall everything while the result queue cannot take the last word
  assign en      = !(root_vld && oq_full);
  assign iq_pop  = en && !iq_empty;
  assign oq_push = root_vld && !oq_full;
  assign ctl.en  = en;
  assign ctl.vld = v_r[PRE-1];

  assign v_nxt  = {v_r[PRE-2:0], iq_pop};
  assign dg_nxt = {dg_r[PRE-3:0], iq_data.degen};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // Products of the cross terms and the centroid reciprocal
  always_comb begin
    logic [2*SUMW-1:0] dp;
    for (int i = 0; i < 3; i++) begin
      pa_nxt[i]   = mul_edge(iq_data.e1[(i + 1) % 3], iq_data.e2[(i + 2) % 3]);
      pb_nxt[i]   = mul_edge(iq_data.e1[(i + 2) % 3], iq_data.e2[(i + 1) % 3]);
      dp          = mul_div3(iq_data.cmag[i]);
      quot_nxt[i] = dp[DIV3_SH +: CW];
    end
  end

  // Cross product and signed centroid
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_nxt[i]   = {pa_r[i][PW-1], pa_r[i]} - {pb_r[i][PW-1], pb_r[i]};
      mid_nxt[i] = cneg_r[i] ? (~quot_r[i] + CW'(1)) : quot_r[i];
    end
  end

  // Magnitudes
  always_comb begin
    logic [XW-1:0] m;
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = x_r[i][XW-1];
      m          = x_r[i][XW-1] ? (~x_r[i] + XW'(1)) : x_r[i];
      mag_nxt[i] = m[MW-1:0];
    end
  end

  // Scale shift from the top bit of the largest magnitude; split squares
  always_comb begin
    logic [MW-1:0] mor;
    logic [HW-1:0] h;
    logic [EW-1:0] l;
    mor   = mag_r[0] | mag_r[1] | mag_r[2];
    k_nxt = '0;
    for (int b = YW; b < MW; b++) begin
      if (mor[b]) begin
        k_nxt = KW'(b - YW + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      h         = mag_r[i][MW-1:EW];
      l         = mag_r[i][EW-1:0];
      hh_nxt[i] = mul_half(EW'(h), EW'(h));
      hl_nxt[i] = mul_half(EW'(h), l);
      ll_nxt[i] = mul_half(l, l);
    end
  end

  // Join partial squares; scale magnitudes
  always_comb begin
    logic [MW-1:0] ysh;
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (SQW'(hh_r[i]) << (2 * EW)) + (SQW'(hl_r[i]) << (EW + 1))
                + SQW'(ll_r[i]);
      ysh       = mag4_r[i] >> k_r;
      y_nxt[i]  = ysh[YW-1:0];
    end
  end

  // Squared length and scaled squares
  always_comb begin
    s_nxt = sq_r[0] + sq_r[1] + sq_r[2];
    for (int i = 0; i < 3; i++) begin
      yy_nxt[i] = mul_y(y_r[i]);
    end
  end

  // Root operands
  always_comb begin
    rin_nxt.v    = s_r >> AREA_SHR;
    rin_nxt.ssum = SSW'(yy_r[0]) + SSW'(yy_r[1]) + SSW'(yy_r[2]);
    for (int i = 0; i < 3; i++) begin
      rin_nxt.tgt[i] = TW'(yy_r[i]) << (2 * NF);
    end
    rin_nxt.nz    = (rin_nxt.ssum != '0);
    rin_nxt.neg   = neg_r[6];
    rin_nxt.mid   = mid_r[6];
    rin_nxt.degen = dg_r[PRE-2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      quot_r   <= quot_nxt;
      cneg_r   <= iq_data.cneg;
      dg_r     <= dg_nxt;
      x_r      <= x_nxt;
      mid_r[2] <= mid_nxt;
      mag_r    <= mag_nxt;
      neg_r[3] <= neg_nxt;
      k_r      <= k_nxt;
      hh_r     <= hh_nxt;
      hl_r     <= hl_nxt;
      ll_r     <= ll_nxt;
      mag4_r   <= mag_r;
      sq_r     <= sq_nxt;
      y_r      <= y_nxt;
      s_r      <= s_nxt;
      yy_r     <= yy_nxt;
      rin_r    <= rin_nxt;
      for (int s = 3; s <= 6; s++) begin
        mid_r[s] <= mid_r[s-1];
      end
      for (int s = 4; s <= 6; s++) begin
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  tnac_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .din     (rin_r),
    .out_vld (root_vld),
    .dout    (oq_data)
  );

endmodule

// ===== rtl/core/triangle_normal_area_centroid_core.sv =====
// Top level of the triangle normal, area and centroid core.
//
//   channel  handshake            ports
//   -------  -------------------  -----------------------------------------------
//   input    push / full          in_a_x .. in_c_z, nine Q12.12 coordinates
//   result   empty / pop          out_normal_x/y/z, out_tri_area, out_mid_x/y/z,
//                                 out_degenerate
//
// One triangle per cycle while the result queue has room. The pipeline depth is set by
// the 50-stage bit-per-stage area square root that follows the front stage, the
// four-entry queue and seven arithmetic stages.
// Reset clears valid bits and queue counts only; no clearing pass.
// A full result queue holds the whole back pipeline; the input side raises full
// once the middle queue is full and the front register is occupied.
`include "triangle_normal_area_centroid_core_macros.svh"
module triangle_normal_area_centroid_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic signed [tnac_pkg::CW-1:0] in_a_x,
  input  logic signed [tnac_pkg::CW-1:0] in_a_y,
  input  logic signed [tnac_pkg::CW-1:0] in_a_z,
  input  logic signed [tnac_pkg::CW-1:0] in_b_x,
  input  logic signed [tnac_pkg::CW-1:0] in_b_y,
  input  logic signed [tnac_pkg::CW-1:0] in_b_z,
  input  logic signed [tnac_pkg::CW-1:0] in_c_x,
  input  logic signed [tnac_pkg::CW-1:0] in_c_y,
  input  logic signed [tnac_pkg::CW-1:0] in_c_z,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [tnac_pkg::NW-1:0] out_normal_x,
  output logic signed [tnac_pkg::NW-1:0] out_normal_y,
  output logic signed [tnac_pkg::NW-1:0] out_normal_z,
  output logic        [tnac_pkg::RW-1:0] out_tri_area,
  output logic signed [tnac_pkg::CW-1:0] out_mid_x,
  output logic signed [tnac_pkg::CW-1:0] out_mid_y,
  output logic signed [tnac_pkg::CW-1:0] out_mid_z,
  output logic                           out_degenerate
);
  import tnac_pkg::*;

  logic    iq_push, iq_full, iq_pop, iq_empty;
  item_t   iq_din, iq_dout;
  logic    oq_push, oq_full;
  result_t oq_din, oq_dout;

  tnac_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .va     ({in_a_z, in_a_y, in_a_x}),
    .vb     ({in_b_z, in_b_y, in_b_x}),
    .vc     ({in_c_z, in_c_y, in_c_x}),
    .q_push (iq_push),
    .q_full (iq_full),
    .q_data (iq_din)
  );

  tnac_fifo #(.T(item_t), .DEPTH(4)) u_iq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (iq_push),
    .full     (iq_full),
    .data_in  (iq_din),
    .pop      (iq_pop),
    .empty    (iq_empty),
    .data_out (iq_dout)
  );

  tnac_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .iq_empty (iq_empty),
    .iq_data  (iq_dout),
    .iq_pop   (iq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_din)
  );

  tnac_fifo #(.T(result_t), .DEPTH(2)) u_oq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (oq_push),
    .full     (oq_full),
    .data_in  (oq_din),
    .pop      (pop),
    .empty    (empty),
    .data_out (oq_dout)
  );

  // Unpack the result word
  assign out_normal_x   = oq_dout.nrm[0];
  assign out_normal_y   = oq_dout.nrm[1];
  assign out_normal_z   = oq_dout.nrm[2];
  assign out_tri_area   = oq_dout.area;
  assign out_mid_x      = oq_dout.mid[0];
  assign out_mid_y      = oq_dout.mid[1];
  assign out_mid_z      = oq_dout.mid[2];
  assign out_degenerate = oq_dout.degen;

  `TNAC_ASSERT_IMP(a_iq_room, iq_push, !iq_full)
  `TNAC_ASSERT_IMP(a_iq_avail, iq_pop, !iq_empty)
  `TNAC_ASSERT_IMP(a_oq_room, oq_push, !oq_full)
  `TNAC_ASSERT_NEXT(a_oq_fill, oq_push, !empty)
  `TNAC_ASSERT_IMP(a_degen_zero, !empty && out_degenerate, oq_dout.nrm == '0 && oq_dout.area == '0)

endmodule
